@@ design/sse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

    localparam int DATA_W = 32;

    // one input transfer
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in;

    // one result transfer
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_res;
        logic                     overflow;
    } t_out;

    // value moving along the cell chain, with its occupancy mark
    typedef struct packed {
        logic                     occ;
        logic signed [DATA_W-1:0] val;
    } t_cell_data;

endpackage

`default_nettype wire

@@ design/selection_sort_engine_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sorting engine for sets of signed 32-bit values.
// Input: present a value with i_start high; it is taken at a clock edge where
// o_busy is low, one per cycle. The transfer with i_in.last set closes the set.
// Up to DEPTH values are kept; further values are dropped and every result
// of that set carries the overflow mark.
// Storage is a chain of DEPTH cells. Each new value enters the first cell;
// every cell keeps the smaller of what it holds and what arrives, and hands
// the larger one to its neighbor on the next cycle, so the chain stays sorted.
// After the closing transfer the block is busy: the last value first
// ripples to its place, then the chain shifts toward the first cell and
// gives one result per cycle on o_out, marked by o_strobe, with last_res
// on the final one. Results never wait, since the receiver cannot stall.
// Reset empties the chain and returns the block to the loading state.
module selection_sort_engine_core
    import sse_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_in  i_in,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out      o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SETTLE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] r_wait;
    logic [CNT_W-1:0] n_wait;
    logic             r_ovf;
    logic             n_ovf;

    logic       accept;
    logic       store_ok;
    logic       shift;
    t_cell_data cell_in;
    t_cell_data held [DEPTH];
    t_cell_data pass [DEPTH];

    assign accept   = i_start && (r_state == ST_LOAD);
    assign store_ok = (r_cnt != CNT_W'(DEPTH));
    assign shift    = (r_state == ST_EMIT);

    assign cell_in.occ = accept && store_ok;
    assign cell_in.val = i_in.value;

    // chain of sorting cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_data from_prev;
        t_cell_data from_next;

        if (g == 0) begin : g_first
            assign from_prev = cell_in;
        end else begin : g_mid
            assign from_prev = pass[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign from_next.occ = 1'b0;
            assign from_next.val = '0;
        end else begin : g_inner
            assign from_next = held[g+1];
        end

        sse_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_in    (from_prev),
            .i_next  (from_next),
            .o_held  (held[g]),
            .o_pass  (pass[g])
        );
    end

    // load, settle and emit sequencing
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_wait  = r_wait;
        n_ovf   = r_ovf;
        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (store_ok) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_wait = n_cnt - CNT_W'(1);
                        if (n_wait == '0) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_SETTLE;
                        end
                    end
                end
            end
            ST_SETTLE: begin
                n_wait = r_wait - CNT_W'(1);
                if (r_wait == CNT_W'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_LOAD;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_wait  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wait  <= n_wait;
            r_ovf   <= n_ovf;
        end
    end

    // result transfer straight from the head cell
    assign o_busy             = (r_state != ST_LOAD);
    assign o_strobe           = shift;
    assign o_out.sorted_value = held[0].val;
    assign o_out.last_res     = (r_cnt == CNT_W'(1));
    assign o_out.overflow     = r_ovf;

    // emitted results always come from an occupied head cell
    a_head_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> held[0].occ)
        else $error("result emitted from an empty cell");

    // final result returns the block to loading with an empty chain
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.last_res) |=> (!o_busy && r_cnt == '0 && !held[0].occ))
        else $error("block not idle after final result");

    // results of a set come out on consecutive cycles
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out.last_res) |=> o_strobe)
        else $error("gap inside a result burst");

    // stored count never exceeds the chain length
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

    // the chain never pushes a value past its last cell
    a_no_spill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pass[DEPTH-1].occ)
        else $error("value pushed past the last cell");

endmodule

`default_nettype wire

@@ design/sse_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sse_cell
    import sse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_shift,
    input  wire t_cell_data i_in,
    input  wire t_cell_data i_next,
    output t_cell_data      o_held,
    output t_cell_data      o_pass
);

    t_cell_data r_held;
    t_cell_data n_held;
    t_cell_data r_pass;
    t_cell_data n_pass;

    // keep the smaller value, hand the larger one up the chain; on shift, take the next cell's value
    always_comb begin
        n_held     = r_held;
        n_pass.occ = 1'b0;
        n_pass.val = i_in.val;
        if (i_shift) begin
            n_held = i_next;
        end else if (i_in.occ) begin
            if (!r_held.occ) begin
                n_held = i_in;
            end else if (i_in.val < r_held.val) begin
                n_held = i_in;
                n_pass = r_held;
            end else begin
                n_pass = i_in;
            end
        end
    end

    // held value and outgoing value registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held.occ <= 1'b0;
            r_pass.occ <= 1'b0;
        end else begin
            r_held <= n_held;
            r_pass <= n_pass;
        end
    end

    assign o_held = r_held;
    assign o_pass = r_pass;

endmodule

`default_nettype wire
